### src/sdd_pkg.sv
// Shared types and date arithmetic for the signed date difference unit.
// No dependencies; used by sdd_day_number and signed_date_difference_days_unit.
`default_nettype none

package sdd_pkg;

  localparam int unsigned YearW = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW = 5;
  localparam int unsigned DiffW = 23;
  // Day numbers from 0000-01-01 stay below 2^23 for 14-bit years; one spare bit
  // lets the subtraction carry a sign.
  localparam int unsigned DayNumW = 24;
  localparam int unsigned DiffMax = 4194303;

  // Reciprocals for exact division of values below 2^15 by 100 and by 400.
  localparam int unsigned Recip100 = 5243;
  localparam int unsigned Shift100 = 19;
  localparam int unsigned Shift400 = 21;

  localparam logic [MonthW-1:0] MonJan = 4'd1;
  localparam logic [MonthW-1:0] MonFeb = 4'd2;
  localparam logic [MonthW-1:0] MonDec = 4'd12;

  typedef struct packed {
    logic [YearW-1:0]  start_year;
    logic [MonthW-1:0] start_month;
    logic [DayW-1:0]   start_day;
    logic [YearW-1:0]  end_year;
    logic [MonthW-1:0] end_month;
    logic [DayW-1:0]   end_day;
    logic              include_end;
  } sdd_in_t;

  typedef struct packed {
    logic signed [DiffW-1:0] day_difference;
    logic                    date_invalid;
  } sdd_out_t;

  // 4/100/400 rule; y % 100 found through a reciprocal multiply.
  function automatic logic leap_year(input logic [YearW-1:0] y);
    logic [27:0] prod;
    logic [8:0]  q100;
    logic        div100;
    prod   = 28'(y) * 28'(Recip100);
    q100   = prod[27:Shift100];
    div100 = (y == 14'(14'(q100) * 14'd100));
    return (y[1:0] == 2'b00) && (!div100 || (q100[1:0] == 2'b00));
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

### src/sdd_day_number.sv
// Converts one Gregorian date to a day count from 0000-01-01 and checks it.
// Depends on sdd_pkg.
`default_nettype none

module sdd_day_number (
  input  wire logic [sdd_pkg::YearW-1:0]   year_i,
  input  wire logic [sdd_pkg::MonthW-1:0]  month_i,
  input  wire logic [sdd_pkg::DayW-1:0]    day_i,
  output logic      [sdd_pkg::DayNumW-1:0] day_num_o,
  output logic                             valid_o
);
  import sdd_pkg::*;

  logic              leap;
  logic [DayW-1:0]   len;
  logic [YearW:0]    y_p3;
  logic [YearW:0]    y_p99;
  logic [YearW:0]    y_p399;
  logic [27:0]       prod100;
  logic [27:0]       prod400;
  logic [8:0]        q100;
  logic [6:0]        q400;
  logic [DayNumW-1:0] base;

  always_comb begin
    leap    = leap_year(year_i);
    len     = month_len(month_i, leap);
    valid_o = (month_i >= MonJan) && (month_i <= MonDec) &&
              (day_i != '0) && (day_i <= len);

    y_p3    = {1'b0, year_i} + 15'd3;
    y_p99   = {1'b0, year_i} + 15'd99;
    y_p399  = {1'b0, year_i} + 15'd399;
    prod100 = 28'(y_p99) * 28'(Recip100);
    prod400 = 28'(y_p399) * 28'(Recip100);
    q100    = prod100[27:Shift100];
    q400    = prod400[27:Shift400];

    // Leap days before this year, then the days of the months gone by.
    base = 24'(year_i) * 24'd365 + 24'(y_p3[YearW:2]) - 24'(q100) + 24'(q400);
    day_num_o = base + 24'(days_before_month(month_i)) +
                24'((month_i > MonFeb) && leap) + 24'(day_i) - 24'd1;
  end

endmodule

`default_nettype wire

### src/signed_date_difference_days_unit.sv
// Signed Gregorian date difference in days: top level.
// From start to done_o a word passes the input register, the day-number register and the
// result register. Throughput one word per cycle; busy stays low.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset clears the valid pipeline only; payload registers are not reset.
// Depends on sdd_pkg and sdd_day_number.
`default_nettype none

module signed_date_difference_days_unit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire sdd_pkg::sdd_in_t item_i,
  output logic                  done_o,
  output sdd_pkg::sdd_out_t     result_o
);
  import sdd_pkg::*;

  logic                s0_valid_q;
  sdd_in_t             s0_item_q;

  logic [DayNumW-1:0]  dn_start;
  logic [DayNumW-1:0]  dn_end;
  logic                ok_start;
  logic                ok_end;

  logic                s1_valid_q;
  logic [DayNumW-1:0]  dn_start_q;
  logic [DayNumW-1:0]  dn_end_q;
  logic                invalid_q;
  logic                inc_q;

  logic [DayNumW-1:0]  diff;
  logic                neg;
  logic [DayNumW-1:0]  mag;
  logic [DayNumW-1:0]  mag_inc;
  logic [DiffW-1:0]    mag_sat;
  sdd_out_t            result_d;
  sdd_out_t            result_q;
  logic                done_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s0_valid_q <= start;
      s1_valid_q <= s0_valid_q;
      done_q     <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      s0_item_q <= item_i;
    end
  end

  sdd_day_number u_start_date (
    .year_i    (s0_item_q.start_year),
    .month_i   (s0_item_q.start_month),
    .day_i     (s0_item_q.start_day),
    .day_num_o (dn_start),
    .valid_o   (ok_start)
  );

  sdd_day_number u_end_date (
    .year_i    (s0_item_q.end_year),
    .month_i   (s0_item_q.end_month),
    .day_i     (s0_item_q.end_day),
    .day_num_o (dn_end),
    .valid_o   (ok_end)
  );

  always_ff @(posedge clk_i) begin
    if (s0_valid_q) begin
      dn_start_q <= dn_start;
      dn_end_q   <= dn_end;
      invalid_q  <= !(ok_start && ok_end);
      inc_q      <= s0_item_q.include_end;
    end
  end

  // Take the magnitude, add the end day, saturate, then restore the sign; an invalid date gives zero.
  always_comb begin
    diff    = dn_end_q - dn_start_q;
    neg     = diff[DayNumW-1];
    mag     = neg ? (~diff + 24'd1) : diff;
    mag_inc = mag + 24'(inc_q);
    mag_sat = (mag_inc > 24'(DiffMax)) ? 23'(DiffMax) : mag_inc[DiffW-1:0];
    if (invalid_q) begin
      result_d.day_difference = '0;
      result_d.date_invalid   = 1'b1;
    end else begin
      result_d.day_difference = neg ? -$signed(mag_sat) : $signed(mag_sat);
      result_d.date_invalid   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

### bench/sdd_checker.sv
// Checker for signed_date_difference_days_unit: watches the command and result channels,
// predicts each result from the accepted word and compares it field by field.
// Depends on sdd_pkg for the word types and the saturation limit.

module sdd_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  sdd_pkg::sdd_in_t  item_i,
  input  logic              done_i,
  input  sdd_pkg::sdd_out_t result_i,
  output int                mismatch_count_o,
  output int                pending_o,
  output int                checked_o,
  output int                invalid_o
);

  sdd_pkg::sdd_out_t difference_q[$];
  int mismatches = 0;
  int checked = 0;
  int invalid_seen = 0;
  int pending = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o = pending;
  assign checked_o = checked;
  assign invalid_o = invalid_seen;

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Month must already be in 1..12.
  function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
    int unsigned len;
    case (m)
      sdd_pkg::MonFeb:   len = is_leap(y) ? 29 : 28;
      4, 6, 9, 11:       len = 30;
      default:           len = 31;
    endcase
    return len;
  endfunction

  function automatic bit calendar_ok(input int unsigned y, input int unsigned m,
                                     input int unsigned d);
    if (m < sdd_pkg::MonJan || m > sdd_pkg::MonDec) return 1'b0;
    return (d >= 1) && (d <= days_in_month(y, m));
  endfunction

  // Days elapsed since 0000-01-01 in the proleptic Gregorian calendar.
  function automatic longint ordinal_day(input int unsigned y, input int unsigned m,
                                         input int unsigned d);
    longint yl;
    longint n;
    yl = longint'(y);
    n = 365 * yl + (yl + 3) / 4 - (yl + 99) / 100 + (yl + 399) / 400;
    for (int unsigned k = 1; k < m; k++) n += days_in_month(y, k);
    return n + longint'(d) - 1;
  endfunction

  function automatic sdd_pkg::sdd_out_t predict_difference(input sdd_pkg::sdd_in_t w);
    sdd_pkg::sdd_out_t res;
    longint diff;
    longint mag;
    bit neg;
    res = '0;
    if (!calendar_ok(w.start_year, w.start_month, w.start_day) ||
        !calendar_ok(w.end_year, w.end_month, w.end_day)) begin
      res.date_invalid = 1'b1;
      return res;
    end
    diff = ordinal_day(w.end_year, w.end_month, w.end_day)
         - ordinal_day(w.start_year, w.start_month, w.start_day);
    neg = diff < 0;
    mag = (neg ? -diff : diff) + longint'(w.include_end);
    // Clamp the magnitude before the sign goes back on.
    if (mag > longint'(sdd_pkg::DiffMax)) mag = longint'(sdd_pkg::DiffMax);
    diff = neg ? -mag : mag;
    res.day_difference = diff[sdd_pkg::DiffW-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    sdd_pkg::sdd_out_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (difference_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("checker: result word with none pending: diff %0d invalid %0b",
                     result_i.day_difference, result_i.date_invalid);
        end else begin
          want = difference_q.pop_front();
          checked++;
          if (want.date_invalid) invalid_seen++;
          if (result_i.day_difference !== want.day_difference ||
              result_i.date_invalid !== want.date_invalid) begin
            mismatches++;
            if (mismatches <= 10)
              $display("checker: mismatch: diff exp %0d got %0d, invalid exp %0b got %0b",
                       want.day_difference, result_i.day_difference,
                       want.date_invalid, result_i.date_invalid);
          end
        end
      end
      if (start_i && !busy_i) difference_q.push_back(predict_difference(item_i));
      pending = difference_q.size();
    end
  end

endmodule

### bench/tb.sv
// Testbench top for signed_date_difference_days_unit: clock, reset, date-pair stimulus
// and the verdict. Depends on sdd_pkg, the unit itself and sdd_checker.

module tb;

  localparam int CycleLimit = 200000;
  localparam int RandomWords = 1300;
  localparam int CalmTail = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  sdd_pkg::sdd_in_t item = '0;
  logic busy;
  logic done_o;
  sdd_pkg::sdd_out_t result_o;

  int mismatch_count;
  int pending;
  int checked;
  int invalid_count;
  int cycles = 0;
  int sent = 0;

  signed_date_difference_days_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item),
    .done_o   (done_o),
    .result_o (result_o)
  );

  sdd_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .item_i           (item),
    .done_i           (done_o),
    .result_i         (result_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .invalid_o        (invalid_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic sdd_pkg::sdd_in_t date_pair(input int sy, input int sm, input int sd,
                                                 input int ey, input int em, input int ed,
                                                 input int inc);
    sdd_pkg::sdd_in_t w;
    w.start_year  = sy[sdd_pkg::YearW-1:0];
    w.start_month = sm[sdd_pkg::MonthW-1:0];
    w.start_day   = sd[sdd_pkg::DayW-1:0];
    w.end_year    = ey[sdd_pkg::YearW-1:0];
    w.end_month   = em[sdd_pkg::MonthW-1:0];
    w.end_day     = ed[sdd_pkg::DayW-1:0];
    w.include_end = inc[0];
    return w;
  endfunction

  function automatic int random_year();
    int y;
    case ($urandom_range(0, 9))
      6:       y = $urandom_range(0, 16383);
      7: begin
        case ($urandom_range(0, 6))
          0: y = 0;
          1: y = 1;
          2: y = 1900;
          3: y = 2000;
          4: y = 2100;
          5: y = 9999;
          default: y = 16383;
        endcase
      end
      8:       y = $urandom_range(1600, 2400);
      9:       y = $urandom_range(10000, 16383);
      default: y = $urandom_range(1, 9999);
    endcase
    return y;
  endfunction

  function automatic int random_month();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
  endfunction

  // Days 29..31 land on month ends, leap days and their invalid neighbours.
  function automatic int random_day();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return $urandom_range(1, 28);
    if (pick < 9) return $urandom_range(29, 31);
    return $urandom_range(0, 31);
  endfunction

  function automatic sdd_pkg::sdd_in_t random_date_pair();
    int sy;
    int sm;
    int sd;
    int kind;
    sy = random_year();
    sm = random_month();
    sd = random_day();
    kind = $urandom_range(0, 9);
    if (kind == 0)
      return date_pair(sy, sm, sd, sy, sm, sd, $urandom_range(0, 1));
    if (kind < 3)
      return date_pair(sy, sm, sd, (sy + $urandom_range(0, 2) - 1) & 16'h3fff,
                       random_month(), random_day(), $urandom_range(0, 1));
    return date_pair(sy, sm, sd, random_year(), random_month(), random_day(),
                     $urandom_range(0, 1));
  endfunction

  task automatic send_date_pair(input sdd_pkg::sdd_in_t w, input int idle_pct);
    int gap;
    logic [63:0] junk;
    start <= 1'b1;
    item <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 7);
      junk = {$urandom, $urandom};
      start <= 1'b0;
      // Put junk on the payload while idle; the unit must ignore it.
      item <= junk[$bits(sdd_pkg::sdd_in_t)-1:0];
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    sdd_pkg::sdd_in_t directed_q[$];
    int idle_pct;
    int directed;
    directed_q = '{
      date_pair(2024, 5, 17, 2024, 5, 17, 0),
      date_pair(2024, 5, 17, 2024, 5, 17, 1),
      date_pair(1, 1, 1, 9999, 12, 31, 0),
      date_pair(9999, 12, 31, 1, 1, 1, 1),
      date_pair(2000, 2, 28, 2000, 3, 1, 0),
      date_pair(2000, 2, 29, 2001, 2, 28, 1),
      date_pair(1900, 2, 29, 1900, 3, 1, 0),
      date_pair(2100, 2, 28, 2100, 2, 29, 0),
      date_pair(2004, 2, 29, 1999, 12, 31, 0),
      date_pair(0, 2, 29, 0, 1, 1, 0),
      date_pair(0, 1, 1, 16383, 12, 31, 1),
      date_pair(16383, 12, 31, 0, 1, 1, 0),
      date_pair(0, 1, 1, 11484, 1, 1, 0),
      date_pair(2023, 0, 10, 2023, 5, 10, 0),
      date_pair(2023, 5, 10, 2023, 13, 10, 1),
      date_pair(2023, 15, 31, 2023, 1, 1, 0),
      date_pair(2023, 4, 31, 2023, 5, 1, 0),
      date_pair(2023, 5, 1, 2023, 6, 0, 0),
      date_pair(16383, 15, 31, 16383, 15, 31, 1),
      date_pair(1, 1, 1, 1, 12, 31, 1),
      date_pair(9999, 12, 31, 9999, 12, 30, 1)
    };
    directed = directed_q.size();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_q[i]) send_date_pair(directed_q[i], 25);
    idle_pct = 0;
    for (int i = 0; i < RandomWords; i++) begin
      // Change the idle pressure every hundred words; keep the tail back to back.
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 50;
        endcase
      end
      if (i >= RandomWords - CalmTail) idle_pct = 0;
      send_date_pair(random_date_pair(), idle_pct);
    end
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("tb: %0d date pairs sent (%0d directed), %0d results checked, %0d invalid",
             sent, directed, checked, invalid_count);
    $display("tb: %0d mismatches, %0d results outstanding", mismatch_count, pending);
    if (mismatch_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
src/sdd_pkg.sv
src/sdd_day_number.sv
src/signed_date_difference_days_unit.sv
bench/sdd_checker.sv
bench/tb.sv
